FILE: design/pspp_pkg.sv
// shared constants, types and helpers for the pipe surface point projection
package pspp_pkg;

  localparam int FRAC_BITS = 24;
  localparam int CW        = 32;
  localparam int DW        = 34;
  localparam int MAGW      = 34;
  localparam int NMW       = 31;
  localparam int SW        = 24;
  localparam int SUMW      = 64;
  localparam int ROOTW     = 32;
  localparam int NUMW      = 56;
  localparam int QW        = 24;
  localparam int RW        = 25;
  localparam int SATW      = 35;
  localparam int SHW       = 6;
  localparam int OPW       = 3;
  localparam int CIW       = 1;

  localparam logic [OPW-1:0] OP_WALL  = 3'd0;
  localparam logic [OPW-1:0] OP_NDISK = 3'd1;
  localparam logic [OPW-1:0] OP_PDISK = 3'd2;
  localparam logic [OPW-1:0] OP_NRIM  = 3'd3;
  localparam logic [OPW-1:0] OP_PRIM  = 3'd4;

  localparam logic [CIW-1:0] CFG_RADIUS = 1'b0;
  localparam logic [CIW-1:0] CFG_END_X  = 1'b1;

  localparam logic [SW-1:0]        RADIUS_RESET = 24'd5033165;
  localparam logic signed [CW-1:0] END_X_RESET  = -(32'sd1 <<< FRAC_BITS);
  localparam logic signed [DW-1:0] HALF_D       = 34'sd1 <<< (FRAC_BITS - 1);
  localparam logic [SW-1:0]        HALF_S       = SW'(1) << (FRAC_BITS - 1);

  typedef logic signed [DW-1:0] dval_t;

  typedef struct packed {
    logic [OPW-1:0]        op;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [CW-1:0]  z;
    logic                  deg;
    dval_t                 c0;
    dval_t                 c1;
  } side_t;

  typedef struct packed {
    dval_t x;
    dval_t y;
    dval_t z;
  } dvec_t;

  typedef struct packed {
    logic [2:0][NMW-1:0] nm;
    logic [2:0]          neg;
    logic                zero;
    side_t               side;
  } sq_tag_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
    side_t      side;
  } div_tag_t;

  function automatic logic signed [CW-1:0] sat32(input logic signed [SATW-1:0] v);
    logic fits;
    fits = (v[SATW-1:CW-1] == {(SATW-CW+1){v[SATW-1]}});
    if (fits) begin
      return v[CW-1:0];
    end else if (v[SATW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

endpackage

FILE: design/pipe_surface_point_projection.sv
// Projects mesh vertices onto a bent-pipe boundary (wall, end disks or rim circles).
// Input channel: in_valid_i / in_ready_o with op_i and pos_x_i, pos_y_i, pos_z_i
// in signed Q7.24; one result beat per input beat on out_valid_o / out_ready_i.
// Config channel: cfg_valid_i / cfg_ready_o, index 0 pipe radius (low 24 bits
// of cfg_data_i), index 1 end plane x; always ready, write only while idle.
// From input beat to result valid the path is two scaled unit
// vector pipelines in series, each 63 stages (32 square root stages and
// 24 divider stages dominate), plus input, middle and output registers.
// Throughput is one beat per cycle while the receiver keeps out_ready_i high.
// Reset clears all valid bits and loads radius 0.3 and end plane x -1.0.
// The output register is backed by a skid register; when the receiver stalls
// the skid register fills and the whole pipeline freezes, dropping in_ready_o,
// so nothing is lost or repeated.
module pipe_surface_point_projection (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pspp_pkg::CIW-1:0]          cfg_index_i,
  input  logic [pspp_pkg::CW-1:0]           cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pspp_pkg::OPW-1:0]          op_i,
  input  logic signed [pspp_pkg::CW-1:0]    pos_x_i,
  input  logic signed [pspp_pkg::CW-1:0]    pos_y_i,
  input  logic signed [pspp_pkg::CW-1:0]    pos_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pspp_pkg::CW-1:0]    out_x_o,
  output logic signed [pspp_pkg::CW-1:0]    out_y_o,
  output logic signed [pspp_pkg::CW-1:0]    out_z_o,
  output logic                              degenerate_o
);
  import pspp_pkg::*;

  logic [SW-1:0]        radius_q;
  logic signed [CW-1:0] endx_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      endx_q   <= END_X_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RADIUS: radius_q <= cfg_data_i[SW-1:0];
        CFG_END_X:  endx_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_valid_q;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  // input register with arc offset vector
  logic  v0_q;
  side_t side0_q;
  dvec_t d0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side0_q.op  <= op_i;
      side0_q.x   <= pos_x_i;
      side0_q.y   <= pos_y_i;
      side0_q.z   <= pos_z_i;
      side0_q.deg <= 1'b0;
      side0_q.c0  <= '0;
      side0_q.c1  <= '0;
      d0_q.x      <= DW'(pos_x_i) - HALF_D;
      d0_q.y      <= DW'(pos_y_i);
      d0_q.z      <= '0;
    end
  end

  logic               u1_valid;
  logic [2:0][RW-1:0] u1_r;
  logic               u1_zero;
  side_t              u1_side;

  pspp_unit u_arc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .d_i     (d0_q),
    .side_i  (side0_q),
    .scale_i (HALF_S),
    .valid_o (u1_valid),
    .r_o     (u1_r),
    .zero_o  (u1_zero),
    .side_o  (u1_side)
  );

  // axis point and tube offset vector
  side_t sidem_c;
  dvec_t dm_c;
  dval_t xs, ys, zs;
  logic  straight;

  always_comb begin
    xs       = DW'(u1_side.x);
    ys       = DW'(u1_side.y);
    zs       = DW'(u1_side.z);
    straight = xs < HALF_D;
    sidem_c  = u1_side;
    dm_c     = '0;
    case (u1_side.op)
      OP_WALL: begin
        if (straight) begin
          sidem_c.c0 = xs;
          sidem_c.c1 = u1_side.y[CW-1] ? -HALF_D : HALF_D;
        end else begin
          sidem_c.c0 = HALF_D + DW'($signed(u1_r[0]));
          sidem_c.c1 = DW'($signed(u1_r[1]));
        end
        sidem_c.deg = !straight && u1_zero;
        dm_c.x      = xs - sidem_c.c0;
        dm_c.y      = ys - sidem_c.c1;
        dm_c.z      = zs;
      end
      OP_NRIM, OP_PRIM: begin
        sidem_c.c1 = (u1_side.op == OP_NRIM) ? -HALF_D : HALF_D;
        dm_c.y     = ys - sidem_c.c1;
        dm_c.z     = zs;
      end
      default: ;
    endcase
  end

  logic  vm_q;
  side_t sidem_q;
  dvec_t dm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= u1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sidem_q <= sidem_c;
      dm_q    <= dm_c;
    end
  end

  logic               u2_valid;
  logic [2:0][RW-1:0] u2_r;
  logic               u2_zero;
  side_t              u2_side;

  pspp_unit u_tube (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vm_q),
    .d_i     (dm_q),
    .side_i  (sidem_q),
    .scale_i (radius_q),
    .valid_o (u2_valid),
    .r_o     (u2_r),
    .zero_o  (u2_zero),
    .side_o  (u2_side)
  );

  // final sums and op select
  logic signed [CW-1:0] res_x, res_y, res_z;
  logic                 res_deg;
  logic signed [CW-1:0] r2_ext;

  always_comb begin
    r2_ext  = CW'($signed(u2_r[2]));
    res_x   = u2_side.x;
    res_y   = u2_side.y;
    res_z   = u2_side.z;
    res_deg = 1'b0;
    case (u2_side.op)
      OP_WALL: begin
        if (u2_side.deg || u2_zero) begin
          res_deg = 1'b1;
        end else begin
          res_x = sat32(SATW'(u2_side.c0) + SATW'($signed(u2_r[0])));
          res_y = sat32(SATW'(u2_side.c1) + SATW'($signed(u2_r[1])));
          res_z = r2_ext;
        end
      end
      OP_NDISK, OP_PDISK: begin
        res_x = endx_q;
      end
      OP_NRIM, OP_PRIM: begin
        if (u2_zero) begin
          res_deg = 1'b1;
        end else begin
          res_x = endx_q;
          res_y = sat32(SATW'(u2_side.c1) + SATW'($signed(u2_r[1])));
          res_z = r2_ext;
        end
      end
      default: ;
    endcase
  end

  // output register with skid
  logic                 out_valid_q;
  logic signed [CW-1:0] out_x_q, out_y_q, out_z_q;
  logic                 out_deg_q;
  logic signed [CW-1:0] skid_x_q, skid_y_q, skid_z_q;
  logic                 skid_deg_q;
  logic                 push;
  logic                 to_skid;
  logic                 load_res;
  logic                 load_skid;

  assign push      = en && u2_valid;
  assign to_skid   = push && out_valid_q && !out_ready_i;
  assign load_res  = push && !to_skid;
  assign load_skid = skid_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (to_skid) begin
        skid_valid_q <= 1'b1;
      end else if (load_skid) begin
        skid_valid_q <= 1'b0;
      end
      if (load_res || load_skid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (to_skid) begin
      skid_x_q   <= res_x;
      skid_y_q   <= res_y;
      skid_z_q   <= res_z;
      skid_deg_q <= res_deg;
    end
    if (load_skid) begin
      out_x_q   <= skid_x_q;
      out_y_q   <= skid_y_q;
      out_z_q   <= skid_z_q;
      out_deg_q <= skid_deg_q;
    end else if (load_res) begin
      out_x_q   <= res_x;
      out_y_q   <= res_y;
      out_z_q   <= res_z;
      out_deg_q <= res_deg;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_z_o      = out_z_q;
  assign degenerate_o = out_deg_q;

endmodule

FILE: design/pspp_sqrt.sv
// pipelined integer square root, one root bit per stage
module pspp_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [pspp_pkg::SUMW-1:0]     sum_i,
  input  pspp_pkg::sq_tag_t             tag_i,
  output logic                          valid_o,
  output logic [pspp_pkg::ROOTW-1:0]    root_o,
  output pspp_pkg::sq_tag_t             tag_o
);
  import pspp_pkg::*;

  localparam int Steps = ROOTW;

  logic             val_q  [Steps];
  logic [SUMW-1:0]  rem_q  [Steps];
  logic [ROOTW-1:0] root_q [Steps];
  sq_tag_t          tag_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Bit = Steps - 1 - k;
    logic             val_in;
    logic [SUMW-1:0]  rem_in;
    logic [ROOTW-1:0] root_in;
    sq_tag_t          tag_in;
    logic [SUMW+1:0]  trial;
    logic             take;

    if (k == 0) begin : g_head
      assign val_in  = valid_i;
      assign rem_in  = sum_i;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_tail
      assign val_in  = val_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    assign trial = ((SUMW+2)'(root_in) << (Bit + 1)) + ((SUMW+2)'(1) << (2 * Bit));
    assign take  = {2'b00, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[k] <= 1'b0;
      end else if (en_i) begin
        val_q[k] <= val_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? SUMW'({2'b00, rem_in} - trial) : rem_in;
        root_q[k] <= take ? (root_in | (ROOTW'(1) << Bit)) : root_in;
        tag_q[k]  <= tag_in;
      end
    end
  end

  assign valid_o = val_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign tag_o   = tag_q[Steps-1];

endmodule

FILE: design/pspp_div.sv
// pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage
module pspp_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [2:0][pspp_pkg::NUMW-1:0]     num_i,
  input  logic [pspp_pkg::ROOTW-1:0]         den_i,
  input  pspp_pkg::div_tag_t                 tag_i,
  output logic                               valid_o,
  output logic [2:0][pspp_pkg::QW-1:0]       quo_o,
  output pspp_pkg::div_tag_t                 tag_o
);
  import pspp_pkg::*;

  localparam int Steps = QW;

  logic                  val_q [Steps];
  logic [2:0][NUMW-1:0]  rem_q [Steps];
  logic [2:0][QW-1:0]    quo_q [Steps];
  logic [ROOTW-1:0]      den_q [Steps];
  div_tag_t              tag_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Bit = Steps - 1 - k;
    logic                 val_in;
    logic [2:0][NUMW-1:0] rem_in;
    logic [2:0][QW-1:0]   quo_in;
    logic [ROOTW-1:0]     den_in;
    div_tag_t             tag_in;
    logic [NUMW-1:0]      dsh;
    logic [2:0][NUMW-1:0] rem_d;
    logic [2:0][QW-1:0]   quo_d;

    if (k == 0) begin : g_head
      assign val_in = valid_i;
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_tail
      assign val_in = val_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign dsh = NUMW'(den_in) << Bit;

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        if (rem_in[j] >= dsh) begin
          rem_d[j] = rem_in[j] - dsh;
          quo_d[j] = quo_in[j] | (QW'(1) << Bit);
        end else begin
          rem_d[j] = rem_in[j];
          quo_d[j] = quo_in[j];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[k] <= 1'b0;
      end else if (en_i) begin
        val_q[k] <= val_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = val_q[Steps-1];
  assign quo_o   = quo_q[Steps-1];
  assign tag_o   = tag_q[Steps-1];

endmodule

FILE: design/pspp_unit.sv
// scaled unit vector pipeline: normalize, sum of squares, square root, divide, sign
module pspp_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  pspp_pkg::dvec_t                d_i,
  input  pspp_pkg::side_t                side_i,
  input  logic [pspp_pkg::SW-1:0]        scale_i,
  output logic                           valid_o,
  output logic [2:0][pspp_pkg::RW-1:0]   r_o,
  output logic                           zero_o,
  output pspp_pkg::side_t                side_o
);
  import pspp_pkg::*;

  // stage 1: magnitudes and largest one
  logic signed [DW-1:0] dc [3];
  logic [2:0][MAGW-1:0] mag_c;
  logic [MAGW-1:0]      max_c;
  logic [2:0]           neg_c;

  assign dc[0] = d_i.x;
  assign dc[1] = d_i.y;
  assign dc[2] = d_i.z;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      neg_c[j] = dc[j][DW-1];
      mag_c[j] = neg_c[j] ? MAGW'(-dc[j]) : MAGW'(dc[j]);
    end
    max_c = mag_c[0];
    if (mag_c[1] > max_c) begin
      max_c = mag_c[1];
    end
    if (mag_c[2] > max_c) begin
      max_c = mag_c[2];
    end
  end

  logic                 v1_q;
  logic [2:0][MAGW-1:0] mag1_q;
  logic [MAGW-1:0]      max1_q;
  logic [2:0]           neg1_q;
  logic                 zero1_q;
  side_t                side1_q;

  // stage 2: leading one position and shift amount
  logic [SHW-1:0] msb_c;
  logic           rsh_c;
  logic [SHW-1:0] amt_c;

  always_comb begin
    msb_c = '0;
    for (int b = 0; b < MAGW; b++) begin
      if (max1_q[b]) begin
        msb_c = SHW'(b);
      end
    end
    rsh_c = msb_c > SHW'(NMW - 1);
    amt_c = rsh_c ? (msb_c - SHW'(NMW - 1)) : (SHW'(NMW - 1) - msb_c);
  end

  logic                 v2_q;
  logic [2:0][MAGW-1:0] mag2_q;
  logic [SHW-1:0]       amt2_q;
  logic                 rsh2_q;
  logic [2:0]           neg2_q;
  logic                 zero2_q;
  side_t                side2_q;

  // stage 3: shift all magnitudes together
  logic [2:0][MAGW-1:0] sh_c;
  logic [2:0][NMW-1:0]  nm_c;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sh_c[j] = rsh2_q ? (mag2_q[j] >> amt2_q) : (mag2_q[j] << amt2_q);
      nm_c[j] = sh_c[j][NMW-1:0];
    end
  end

  logic                v3_q;
  logic [2:0][NMW-1:0] nm3_q;
  logic [2:0]          neg3_q;
  logic                zero3_q;
  side_t               side3_q;

  // stage 4: squares
  logic [2:0][2*NMW-1:0] sq_c;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sq_c[j] = nm3_q[j] * nm3_q[j];
    end
  end

  logic                  v4_q;
  logic [2:0][2*NMW-1:0] sq4_q;
  sq_tag_t               tag4_q;

  // stage 5: sum of squares
  logic    v5_q;
  logic [SUMW-1:0] sum5_q;
  sq_tag_t tag5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag_c;
      max1_q  <= max_c;
      neg1_q  <= neg_c;
      zero1_q <= (max_c == '0);
      side1_q <= side_i;

      mag2_q  <= mag1_q;
      amt2_q  <= amt_c;
      rsh2_q  <= rsh_c;
      neg2_q  <= neg1_q;
      zero2_q <= zero1_q;
      side2_q <= side1_q;

      nm3_q   <= nm_c;
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
      side3_q <= side2_q;

      sq4_q       <= sq_c;
      tag4_q.nm   <= nm3_q;
      tag4_q.neg  <= neg3_q;
      tag4_q.zero <= zero3_q;
      tag4_q.side <= side3_q;

      sum5_q <= SUMW'(sq4_q[0]) + SUMW'(sq4_q[1]) + SUMW'(sq4_q[2]);
      tag5_q <= tag4_q;
    end
  end

  logic             sv;
  logic [ROOTW-1:0] root;
  sq_tag_t          stag;

  pspp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v5_q),
    .sum_i   (sum5_q),
    .tag_i   (tag5_q),
    .valid_o (sv),
    .root_o  (root),
    .tag_o   (stag)
  );

  // stage 6: scaled numerators with rounding half
  logic [2:0][NMW+SW-1:0] prod_c;
  logic [2:0][NUMW-1:0]   num_c;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod_c[j] = stag.nm[j] * scale_i;
      num_c[j]  = NUMW'(prod_c[j]) + NUMW'(root >> 1);
    end
  end

  logic                 v6_q;
  logic [2:0][NUMW-1:0] num6_q;
  logic [ROOTW-1:0]     den6_q;
  div_tag_t             tag6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en_i) begin
      v6_q <= sv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num6_q      <= num_c;
      den6_q      <= root;
      tag6_q.neg  <= stag.neg;
      tag6_q.zero <= stag.zero;
      tag6_q.side <= stag.side;
    end
  end

  logic               dv;
  logic [2:0][QW-1:0] quo;
  div_tag_t           dtag;

  pspp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v6_q),
    .num_i   (num6_q),
    .den_i   (den6_q),
    .tag_i   (tag6_q),
    .valid_o (dv),
    .quo_o   (quo),
    .tag_o   (dtag)
  );

  // stage 7: restore signs
  logic [2:0][RW-1:0] r_c;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      r_c[j] = dtag.neg[j] ? (-RW'(quo[j])) : RW'(quo[j]);
    end
  end

  logic               v7_q;
  logic [2:0][RW-1:0] r7_q;
  logic               zero7_q;
  side_t              side7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en_i) begin
      v7_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r7_q    <= r_c;
      zero7_q <= dtag.zero;
      side7_q <= dtag.side;
    end
  end

  assign valid_o = v7_q;
  assign r_o     = r7_q;
  assign zero_o  = zero7_q;
  assign side_o  = side7_q;

endmodule
